FILE: src/tcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

   // Default vertex coordinate width (Q4.12) and polygon buffer depth.
   localparam int COORD_WIDTH_DEF    = 16;
   localparam int MAX_POLY_VERTS_DEF = 9;

   // Fixed field widths and counts.
   localparam int COLOR_W    = 32;
   localparam int TRI_VERTS  = 3;
   localparam int NUM_PLANES = 6;

   // Depth of the triangle queue between front and back; a power of two.
   localparam int TRI_QUEUE_DEPTH = 2;

   // Status of the triangle queue, seen by both of its sides.
   typedef struct packed {
      logic full;
      logic empty;
   } tcc_qstat_type;

endpackage

`default_nettype wire

FILE: src/tcc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tcc_front import tcc_pkg::*; #(
   parameter int W = COORD_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [W-1:0]                req_pos_x,
   input  logic signed [W-1:0]                req_pos_y,
   input  logic signed [W-1:0]                req_pos_z,
   input  logic [COLOR_W-1:0]                 req_color,
   input  tcc_qstat_type                      q_stat,
   output logic                               q_push,
   output logic [TRI_VERTS*(3*W+COLOR_W)-1:0] q_data
);

   localparam int VW   = 3*W + COLOR_W;
   localparam int DW   = W + 1;
   localparam int PW   = 2*DW;
   localparam int CW   = PW + 1;
   localparam int TW   = W + 1;
   localparam int DOTW = 3*W + 6;
   localparam int BCW  = $clog2(W + 1);
   localparam logic signed [W-1:0] ONE_C = W'(64'sd1 << (W - 4));

   localparam logic [2:0] F_COLLECT = 3'd0;
   localparam logic [2:0] F_PROD    = 3'd1;
   localparam logic [2:0] F_TLOAD   = 3'd2;
   localparam logic [2:0] F_TMAC    = 3'd3;
   localparam logic [2:0] F_PUSH    = 3'd4;

   function automatic logic signed [W-1:0] crd_of(input logic [VW-1:0] v, input logic [1:0] c);
      case (c)
         2'd0:    crd_of = v[VW-1 -: W];
         2'd1:    crd_of = v[VW-1-W -: W];
         default: crd_of = v[VW-1-2*W -: W];
      endcase
   endfunction

   logic [2:0]              state_ff, state_in;
   logic [1:0]              phase_ff, phase_in;
   logic [VW-1:0]           vert0_ff, vert0_in, vert1_ff, vert1_in, vert2_ff, vert2_in;
   logic signed [DW-1:0]    a_ff [3], a_in [3], b_ff [3], b_in [3];
   logic signed [TW-1:0]    t_ff [3], t_in [3];
   logic signed [CW-1:0]    c_ff [3], c_in [3];
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic [2:0]              step_ff, step_in;
   logic [1:0]              term_ff, term_in;
   logic [BCW-1:0]          bit_ff, bit_in;
   logic signed [DOTW-1:0]  csh_ff, csh_in, dot_ff, dot_in;
   logic [TW-1:0]           tsh_ff, tsh_in;

   logic                    accept;
   logic [VW-1:0]           vin;
   logic signed [DW-1:0]    ma, mb;
   logic [1:0]              acc_idx;

   assign req_stall = (state_ff != F_COLLECT);
   assign accept    = req_valid && !req_stall;
   assign vin       = {req_pos_x, req_pos_y, req_pos_z, req_color};
   assign q_data    = {vert0_ff, vert1_ff, vert2_ff};
   assign acc_idx   = 2'((step_ff - 3'd1) >> 1);

   // Operand pairs of the cross product, two per normal component.
   always_comb begin
      case (step_ff)
         3'd0:    begin ma = a_ff[1]; mb = b_ff[2]; end
         3'd1:    begin ma = a_ff[2]; mb = b_ff[1]; end
         3'd2:    begin ma = a_ff[2]; mb = b_ff[0]; end
         3'd3:    begin ma = a_ff[0]; mb = b_ff[2]; end
         3'd4:    begin ma = a_ff[0]; mb = b_ff[1]; end
         default: begin ma = a_ff[1]; mb = b_ff[0]; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      vert0_in = vert0_ff;
      vert1_in = vert1_ff;
      vert2_in = vert2_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      t_in     = t_ff;
      c_in     = c_ff;
      prod_in  = prod_ff;
      step_in  = step_ff;
      term_in  = term_ff;
      bit_in   = bit_ff;
      csh_in   = csh_ff;
      tsh_in   = tsh_ff;
      dot_in   = dot_ff;
      q_push   = 1'b0;
      case (state_ff)
         F_COLLECT: begin
            if (accept) begin
               case (phase_ff)
                  2'd0: begin
                     vert0_in = vin;
                     phase_in = 2'd1;
                  end
                  2'd1: begin
                     vert1_in = vin;
                     phase_in = 2'd2;
                  end
                  default: begin
                     vert2_in = vin;
                     phase_in = 2'd0;
                     for (int i = 0; i < 3; i++) begin
                        a_in[i] = DW'(crd_of(vert1_ff, 2'(i))) - DW'(crd_of(vert0_ff, 2'(i)));
                        b_in[i] = DW'(crd_of(vin, 2'(i))) - DW'(crd_of(vert0_ff, 2'(i)));
                        t_in[i] = TW'(crd_of(vert0_ff, 2'(i)));
                        c_in[i] = '0;
                     end
                     t_in[2]  = TW'(crd_of(vert0_ff, 2'd2)) + TW'(ONE_C);
                     dot_in   = '0;
                     step_in  = 3'd0;
                     term_in  = 2'd0;
                     state_in = F_PROD;
                  end
               endcase
            end
         end
         F_PROD: begin
            // Multiply one pair per cycle, fold in the previous product.
            prod_in = ma * mb;
            if (step_ff != 3'd0) begin
               if (step_ff[0])
                  c_in[acc_idx] = c_ff[acc_idx] + CW'(prod_ff);
               else
                  c_in[acc_idx] = c_ff[acc_idx] - CW'(prod_ff);
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd6)
               state_in = F_TLOAD;
         end
         F_TLOAD: begin
            csh_in   = DOTW'(c_ff[term_ff]);
            tsh_in   = t_ff[term_ff];
            bit_in   = '0;
            state_in = F_TMAC;
         end
         F_TMAC: begin
            // Shift-add multiply by the eye vector; the top bit weighs negative.
            if (tsh_ff[0]) begin
               if (bit_ff == BCW'(W))
                  dot_in = dot_ff - csh_ff;
               else
                  dot_in = dot_ff + csh_ff;
            end
            csh_in = csh_ff <<< 1;
            tsh_in = tsh_ff >> 1;
            bit_in = bit_ff + BCW'(1);
            if (bit_ff == BCW'(W)) begin
               if (term_ff == 2'd2) begin
                  state_in = F_PUSH;
               end else begin
                  term_in  = term_ff + 2'd1;
                  state_in = F_TLOAD;
               end
            end
         end
         F_PUSH: begin
            if (!dot_ff[DOTW-1] && (dot_ff != '0)) begin
               state_in = F_COLLECT;
            end else if (!q_stat.full) begin
               q_push   = 1'b1;
               state_in = F_COLLECT;
            end
         end
         default: state_in = F_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_COLLECT;
         phase_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
      vert0_ff <= vert0_in;
      vert1_ff <= vert1_in;
      vert2_ff <= vert2_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      t_ff     <= t_in;
      c_ff     <= c_in;
      prod_ff  <= prod_in;
      step_ff  <= step_in;
      term_ff  <= term_in;
      bit_ff   <= bit_in;
      csh_ff   <= csh_in;
      tsh_ff   <= tsh_in;
      dot_ff   <= dot_in;
   end

endmodule

`default_nettype wire

FILE: src/tcc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tcc_queue import tcc_pkg::*; #(
   parameter int ENTRY_W = TRI_VERTS*(3*COORD_WIDTH_DEF+COLOR_W)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [ENTRY_W-1:0] push_data,
   input  logic               pop,
   output logic [ENTRY_W-1:0] pop_data,
   output tcc_qstat_type      stat
);

   localparam int PTR_W = (TRI_QUEUE_DEPTH > 1) ? $clog2(TRI_QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TRI_QUEUE_DEPTH + 1);

   logic [ENTRY_W-1:0] slot_ff [TRI_QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign stat.full  = (cnt_ff == CNT_W'(TRI_QUEUE_DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push)
         slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

FILE: src/tcc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tcc_back import tcc_pkg::*; #(
   parameter int W    = COORD_WIDTH_DEF,
   parameter int MAXV = MAX_POLY_VERTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tcc_qstat_type                      q_stat,
   output logic                               q_pop,
   input  logic [TRI_VERTS*(3*W+COLOR_W)-1:0] q_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [W-1:0]                rsp_out_x,
   output logic signed [W-1:0]                rsp_out_y,
   output logic signed [W-1:0]                rsp_out_z,
   output logic [COLOR_W-1:0]                 rsp_out_color,
   output logic                               rsp_last
);

   localparam int VW   = 3*W + COLOR_W;
   localparam int TRW  = TRI_VERTS*VW;
   localparam int IDXW = $clog2(MAXV);
   localparam int CNTW = $clog2(MAXV + 1);
   localparam int DW   = W + 1;
   localparam int PW   = 2*DW;
   localparam int QW   = W + 2;
   localparam int RW   = W + 2;
   localparam int DCW  = $clog2(PW + 1);
   localparam logic signed [W-1:0] ONE_C     = W'(64'sd1 << (W - 4));
   localparam logic signed [W-1:0] NEG_ONE_C = -ONE_C;

   localparam logic [4:0] B_IDLE   = 5'd0;
   localparam logic [4:0] B_LOAD   = 5'd1;
   localparam logic [4:0] B_PSTART = 5'd2;
   localparam logic [4:0] B_PREV   = 5'd3;
   localparam logic [4:0] B_CUR    = 5'd4;
   localparam logic [4:0] B_EVAL   = 5'd5;
   localparam logic [4:0] B_MUL    = 5'd6;
   localparam logic [4:0] B_DINIT  = 5'd7;
   localparam logic [4:0] B_DSTEP  = 5'd8;
   localparam logic [4:0] B_DFIN   = 5'd9;
   localparam logic [4:0] B_PUSHX  = 5'd10;
   localparam logic [4:0] B_PUSHC  = 5'd11;
   localparam logic [4:0] B_ADV    = 5'd12;
   localparam logic [4:0] B_PEND   = 5'd13;
   localparam logic [4:0] B_FSTART = 5'd14;
   localparam logic [4:0] B_FREAD  = 5'd15;
   localparam logic [4:0] B_FWAIT  = 5'd16;

   function automatic logic signed [W-1:0] crd_of(input logic [VW-1:0] v, input logic [1:0] c);
      case (c)
         2'd0:    crd_of = v[VW-1 -: W];
         2'd1:    crd_of = v[VW-1-W -: W];
         default: crd_of = v[VW-1-2*W -: W];
      endcase
   endfunction

   function automatic logic [VW-1:0] set_crd(input logic [VW-1:0] v, input logic [1:0] c,
                                             input logic [W-1:0] val);
      logic [VW-1:0] r;
      r = v;
      case (c)
         2'd0:    r[VW-1 -: W] = val;
         2'd1:    r[VW-1-W -: W] = val;
         default: r[VW-1-2*W -: W] = val;
      endcase
      set_crd = r;
   endfunction

   function automatic logic [1:0] plane_axis(input logic [2:0] p);
      case (p)
         3'd0, 3'd3: plane_axis = 2'd0;
         3'd1, 3'd4: plane_axis = 2'd1;
         default:    plane_axis = 2'd2;
      endcase
   endfunction

   function automatic logic is_inside(input logic signed [W-1:0] v, input logic pos);
      is_inside = pos ? (v <= ONE_C) : (v >= NEG_ONE_C);
   endfunction

   // Two polygon buffers, used in turn as source and destination of a pass.
   logic [VW-1:0]   mem [2][MAXV];
   logic [VW-1:0]   rd_data_ff;
   logic            rd_en, rd_buf, wr_en, wr_buf;
   logic [IDXW-1:0] rd_idx, wr_idx;
   logic [VW-1:0]   wr_data;

   logic [4:0]           state_ff, state_in;
   logic                 src_ff, src_in;
   logic [CNTW-1:0]      src_cnt_ff, src_cnt_in, dst_cnt_ff, dst_cnt_in, k_ff, k_in;
   logic [2:0]           plane_ff, plane_in;
   logic [TRW-1:0]       tri_ff, tri_in;
   logic [1:0]           ld_ff, ld_in, crd_ff, crd_in;
   logic [VW-1:0]        prev_ff, prev_in, cur_ff, cur_in, nx_ff, nx_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [PW-1:0]        nm_ff, nm_in;
   logic [DW-1:0]        den_ff, den_in;
   logic [RW-1:0]        rem_ff, rem_in;
   logic [QW-1:0]        q_ff, q_in;
   logic                 neg_ff, neg_in;
   logic [DCW-1:0]       dcnt_ff, dcnt_in;
   logic [CNTW-1:0]      fk_ff, fk_in;
   logic [1:0]           fv_ff, fv_in;
   logic                 ovalid_ff, ovalid_in, olast_ff, olast_in;
   logic [VW-1:0]        overt_ff, overt_in;

   logic [1:0]           ax;
   logic                 spos, in_c, in_p, fan_last, out_ok, rnd;
   logic signed [W-1:0]  su, fa, ta, fc, tc;
   logic signed [DW-1:0] da;
   logic [RW-1:0]        sh;
   logic [QW-1:0]        qr;
   logic signed [W+2:0]  sval, ncrd;
   logic [CNTW-1:0]      fan_idx;

   assign ax   = plane_axis(plane_ff);
   assign spos = (plane_ff < 3'd3);
   assign su   = spos ? ONE_C : NEG_ONE_C;
   assign fa   = crd_of(prev_ff, ax);
   assign ta   = crd_of(cur_ff, ax);
   assign fc   = crd_of(prev_ff, crd_ff);
   assign tc   = crd_of(cur_ff, crd_ff);
   assign da   = DW'(ta) - DW'(fa);
   assign in_c = is_inside(ta, spos);
   assign in_p = is_inside(fa, spos);
   assign sh   = {rem_ff[RW-2:0], nm_ff[PW-1]};
   assign rnd  = ({1'b0, rem_ff, 1'b0} >= {2'b00, den_ff});
   assign qr   = q_ff + QW'(rnd);
   assign sval = neg_ff ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
   assign ncrd = (W+3)'(fc) + sval;

   assign out_ok   = !ovalid_ff || !rsp_stall;
   assign fan_last = (fk_ff == src_cnt_ff - CNTW'(TRI_VERTS)) && (fv_ff == 2'd2);

   always_comb begin
      if (fk_ff == '0)
         fan_idx = CNTW'(fv_ff);
      else begin
         case (fv_ff)
            2'd0:    fan_idx = fk_ff + CNTW'(1);
            2'd1:    fan_idx = fk_ff + CNTW'(2);
            default: fan_idx = '0;
         endcase
      end
   end

   always_comb begin
      state_in   = state_ff;
      src_in     = src_ff;
      src_cnt_in = src_cnt_ff;
      dst_cnt_in = dst_cnt_ff;
      k_in       = k_ff;
      plane_in   = plane_ff;
      tri_in     = tri_ff;
      ld_in      = ld_ff;
      crd_in     = crd_ff;
      prev_in    = prev_ff;
      cur_in     = cur_ff;
      nx_in      = nx_ff;
      prod_in    = prod_ff;
      nm_in      = nm_ff;
      den_in     = den_ff;
      rem_in     = rem_ff;
      q_in       = q_ff;
      neg_in     = neg_ff;
      dcnt_in    = dcnt_ff;
      fk_in      = fk_ff;
      fv_in      = fv_ff;
      overt_in   = overt_ff;
      olast_in   = olast_ff;
      ovalid_in  = (ovalid_ff && rsp_stall);
      q_pop      = 1'b0;
      rd_en      = 1'b0;
      rd_buf     = src_ff;
      rd_idx     = '0;
      wr_en      = 1'b0;
      wr_buf     = !src_ff;
      wr_idx     = dst_cnt_ff[IDXW-1:0];
      wr_data    = cur_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_stat.empty) begin
               q_pop    = 1'b1;
               tri_in   = q_data;
               ld_in    = 2'd0;
               state_in = B_LOAD;
            end
         end
         B_LOAD: begin
            wr_en   = 1'b1;
            wr_buf  = 1'b0;
            wr_idx  = IDXW'(ld_ff);
            wr_data = tri_ff[TRW-1-ld_ff*VW -: VW];
            ld_in   = ld_ff + 2'd1;
            if (ld_ff == 2'd2) begin
               src_in     = 1'b0;
               src_cnt_in = CNTW'(TRI_VERTS);
               plane_in   = 3'd0;
               state_in   = B_PSTART;
            end
         end
         B_PSTART: begin
            dst_cnt_in = '0;
            if (src_cnt_ff == '0) begin
               state_in = B_PEND;
            end else begin
               rd_en    = 1'b1;
               rd_idx   = IDXW'(src_cnt_ff - CNTW'(1));
               state_in = B_PREV;
            end
         end
         B_PREV: begin
            prev_in  = rd_data_ff;
            k_in     = '0;
            rd_en    = 1'b1;
            rd_idx   = '0;
            state_in = B_CUR;
         end
         B_CUR: begin
            cur_in   = rd_data_ff;
            state_in = B_EVAL;
         end
         B_EVAL: begin
            if (in_c != in_p) begin
               if (da == '0) begin
                  state_in = in_c ? B_PUSHC : B_ADV;
               end else begin
                  nx_in[COLOR_W-1:0] = prev_ff[COLOR_W-1:0];
                  crd_in   = 2'd0;
                  state_in = B_MUL;
               end
            end else begin
               state_in = in_c ? B_PUSHC : B_ADV;
            end
         end
         B_MUL: begin
            if (crd_ff == ax) begin
               nx_in = set_crd(nx_ff, crd_ff, su);
               if (crd_ff == 2'd2)
                  state_in = B_PUSHX;
               else
                  crd_in = crd_ff + 2'd1;
            end else begin
               prod_in  = (DW'(tc) - DW'(fc)) * (DW'(su) - DW'(fa));
               state_in = B_DINIT;
            end
         end
         B_DINIT: begin
            neg_in   = prod_ff[PW-1] ^ da[DW-1];
            nm_in    = prod_ff[PW-1] ? PW'(-prod_ff) : PW'(prod_ff);
            den_in   = da[DW-1] ? DW'(-da) : DW'(da);
            rem_in   = '0;
            q_in     = '0;
            dcnt_in  = '0;
            state_in = B_DSTEP;
         end
         B_DSTEP: begin
            // Restoring division, one quotient bit per cycle.
            nm_in = nm_ff << 1;
            if (sh >= RW'(den_ff)) begin
               rem_in = sh - RW'(den_ff);
               q_in   = {q_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = sh;
               q_in   = {q_ff[QW-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + DCW'(1);
            if (dcnt_ff == DCW'(PW - 1))
               state_in = B_DFIN;
         end
         B_DFIN: begin
            nx_in = set_crd(nx_ff, crd_ff, ncrd[W-1:0]);
            if (crd_ff == 2'd2) begin
               state_in = B_PUSHX;
            end else begin
               crd_in   = crd_ff + 2'd1;
               state_in = B_MUL;
            end
         end
         B_PUSHX: begin
            if (dst_cnt_ff < CNTW'(MAXV)) begin
               wr_en      = 1'b1;
               wr_data    = nx_ff;
               dst_cnt_in = dst_cnt_ff + CNTW'(1);
            end
            state_in = in_c ? B_PUSHC : B_ADV;
         end
         B_PUSHC: begin
            if (dst_cnt_ff < CNTW'(MAXV)) begin
               wr_en      = 1'b1;
               wr_data    = cur_ff;
               dst_cnt_in = dst_cnt_ff + CNTW'(1);
            end
            state_in = B_ADV;
         end
         B_ADV: begin
            prev_in = cur_ff;
            if (k_ff + CNTW'(1) == src_cnt_ff) begin
               state_in = B_PEND;
            end else begin
               k_in     = k_ff + CNTW'(1);
               rd_en    = 1'b1;
               rd_idx   = IDXW'(k_ff + CNTW'(1));
               state_in = B_CUR;
            end
         end
         B_PEND: begin
            src_in     = !src_ff;
            src_cnt_in = dst_cnt_ff;
            if (plane_ff == 3'(NUM_PLANES - 1)) begin
               state_in = B_FSTART;
            end else begin
               plane_in = plane_ff + 3'd1;
               state_in = B_PSTART;
            end
         end
         B_FSTART: begin
            if (src_cnt_ff < CNTW'(TRI_VERTS)) begin
               state_in = B_IDLE;
            end else begin
               fk_in    = '0;
               fv_in    = 2'd0;
               state_in = B_FREAD;
            end
         end
         B_FREAD: begin
            rd_en    = 1'b1;
            rd_idx   = fan_idx[IDXW-1:0];
            state_in = B_FWAIT;
         end
         B_FWAIT: begin
            if (out_ok) begin
               ovalid_in = 1'b1;
               overt_in  = rd_data_ff;
               olast_in  = fan_last;
               if (fv_ff == 2'd2) begin
                  fv_in = 2'd0;
                  fk_in = fk_ff + CNTW'(1);
               end else begin
                  fv_in = fv_ff + 2'd1;
               end
               state_in = fan_last ? B_IDLE : B_FREAD;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_buf][wr_idx] <= wr_data;
      if (rd_en)
         rd_data_ff <= mem[rd_buf][rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_IDLE;
         ovalid_ff  <= 1'b0;
         src_cnt_ff <= '0;
         dst_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         ovalid_ff  <= ovalid_in;
         src_cnt_ff <= src_cnt_in;
         dst_cnt_ff <= dst_cnt_in;
      end
      src_ff   <= src_in;
      k_ff     <= k_in;
      plane_ff <= plane_in;
      tri_ff   <= tri_in;
      ld_ff    <= ld_in;
      crd_ff   <= crd_in;
      prev_ff  <= prev_in;
      cur_ff   <= cur_in;
      nx_ff    <= nx_in;
      prod_ff  <= prod_in;
      nm_ff    <= nm_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      neg_ff   <= neg_in;
      dcnt_ff  <= dcnt_in;
      fk_ff    <= fk_in;
      fv_ff    <= fv_in;
      overt_ff <= overt_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid     = ovalid_ff;
   assign rsp_out_x     = crd_of(overt_ff, 2'd0);
   assign rsp_out_y     = crd_of(overt_ff, 2'd1);
   assign rsp_out_z     = crd_of(overt_ff, 2'd2);
   assign rsp_out_color = overt_ff[COLOR_W-1:0];
   assign rsp_last      = olast_ff;

   a_dst_bound: assert property (@(posedge clock) disable iff (reset)
      dst_cnt_ff <= CNTW'(MAXV))
      else $error("polygon count beyond buffer depth");

   a_fan_size: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_FWAIT) |-> (src_cnt_ff >= CNTW'(TRI_VERTS)))
      else $error("fan emitted from a degenerate polygon");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DFIN) |-> (rem_ff < RW'(den_ff)))
      else $error("division remainder not below divisor");

endmodule

`default_nettype wire

FILE: src/triangle_cull_and_cube_clip.sv
// Triangle back-face cull and clip to the cube [-1,1]^3.
// The req_ channel takes one vertex per transfer (Q4.12 position plus a color
// word), three per triangle. The rsp_ channel gives the clipped polygon as a
// triangle list, three vertices per triangle, with rsp_last on the final
// vertex of each input triangle. Culled or fully clipped triangles give none.
// The first two vertices of a triangle are taken without a stall. The third
// holds req_stall high while one multiplier and one shift-add unit evaluate
// the facing test and until the triangle is dropped or queued; a two-entry
// queue then hands the triangle to the clipper, so culling runs ahead.
// The clipper makes six plane passes over the polygon. Each new edge crossing
// goes through its single restoring divider, once for every coordinate but
// the one of the plane's axis. Emission reads each output vertex through the
// one read port of the polygon memory. When the receiver stalls, the output
// register holds its vertex and the clipper waits; the front keeps culling
// until the queue is full. Synchronous reset empties the queue, clears the
// vertex count and drops any pending output; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module triangle_cull_and_cube_clip import tcc_pkg::*; #(
   parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
   parameter int MAX_POLY_VERTS = MAX_POLY_VERTS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  logic [COLOR_W-1:0]           req_color,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_z,
   output logic [COLOR_W-1:0]           rsp_out_color,
   output logic                         rsp_last
);

   // One queue entry is a whole triangle: three packed vertices.
   localparam int TRI_W = TRI_VERTS*(3*COORD_WIDTH + COLOR_W);

   tcc_qstat_type    q_stat;
   logic             q_push, q_pop;
   logic [TRI_W-1:0] q_wdata, q_rdata;

   // Front: collects vertices and drops triangles that face away.
   tcc_front #(.W(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_pos_x (req_pos_x),
      .req_pos_y (req_pos_y),
      .req_pos_z (req_pos_z),
      .req_color (req_color),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_data    (q_wdata)
   );

   tcc_queue #(.ENTRY_W(TRI_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .stat      (q_stat)
   );

   // Back: clips each kept triangle and emits the fan.
   tcc_back #(.W(COORD_WIDTH), .MAXV(MAX_POLY_VERTS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_stat        (q_stat),
      .q_pop         (q_pop),
      .q_data        (q_rdata),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_out_color (rsp_out_color),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire
